// ===== src/i2cbs_pkg.sv =====
package i2cbs_pkg;

  // command codes carried in kind
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_SEND    = 3'd2;
  localparam logic [2:0] KIND_RECV    = 3'd3;
  localparam logic [2:0] KIND_SEND_AK = 3'd4;
  localparam logic [2:0] KIND_RECV_AK = 3'd5;
  localparam logic [2:0] KIND_SAMPLE  = 3'd6;

  // receive wait modes
  localparam logic [1:0] WAIT_IDLE = 2'd0;
  localparam logic [1:0] WAIT_BYTE = 2'd1;
  localparam logic [1:0] WAIT_ACK  = 2'd2;

  // internal operation, resolved on the first step of an item
  localparam logic [3:0] OP_FAULT    = 4'd0;
  localparam logic [3:0] OP_START    = 4'd1;
  localparam logic [3:0] OP_STOP     = 4'd2;
  localparam logic [3:0] OP_SEND     = 4'd3;
  localparam logic [3:0] OP_RECV     = 4'd4;
  localparam logic [3:0] OP_SEND_AK  = 4'd5;
  localparam logic [3:0] OP_RECV_AK  = 4'd6;
  localparam logic [3:0] OP_SMP_ACK  = 4'd7;
  localparam logic [3:0] OP_SMP_BYTE = 4'd8;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [4:0] SEND_LAST_STEP = 5'd23;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       ack_value;
    logic       sda_in;
  } i2cbs_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_is_ack;
    logic       fault;
    logic       last;
  } i2cbs_out_t;

endpackage

// ===== src/i2c_master_bit_sequencer_unit.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    i2cbs_in_t  (command or SDA sample)
// out_     output     out_valid / out_ready  i2cbs_out_t (one pin step per word)
//
// One result word per cycle while the output does not stall. An item makes
// 1 word (fault, final sample), 2 (other samples) up to 24 (send byte), paced by
// the single step counter. The first word follows once the item is registered.
// The next item is taken in the cycle the current item's last word is loaded.
// Synchronous active-low reset releases both pins and clears the receive state.
// A stalled output register holds its word and halts the step counter.
module i2c_master_bit_sequencer_unit
  import i2cbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  i2cbs_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output i2cbs_out_t out_data
);

  logic       busy_r;
  i2cbs_in_t  cmd_r;
  logic [3:0] op_r;
  logic [4:0] step_r;
  logic [1:0] phase_r;
  logic [2:0] bit_r;

  logic       scl_r, sda_r;
  logic [1:0] wait_r;
  logic [3:0] bits_r;
  logic [7:0] shift_r;

  logic       out_valid_r;
  i2cbs_out_t out_r;

  logic       adv;
  logic       waiting;
  logic [3:0] op_dec, op_cur;
  logic       scl_nxt, sda_nxt;
  logic [1:0] wait_nxt;
  logic [3:0] bits_nxt;
  logic [7:0] shift_nxt;
  logic [7:0] rx_nxt;
  logic       rxv_nxt, ack_nxt, flt_nxt, lst_nxt;
  logic [7:0] smp_shift;
  logic [3:0] smp_bits;

  assign waiting = (wait_r == WAIT_BYTE) || (wait_r == WAIT_ACK);
  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (adv && lst_nxt);

  always_comb begin
    op_dec = OP_FAULT;
    case (cmd_r.kind)
      KIND_START:   op_dec = waiting ? OP_FAULT : OP_START;
      KIND_STOP:    op_dec = waiting ? OP_FAULT : OP_STOP;
      KIND_SEND:    op_dec = waiting ? OP_FAULT : OP_SEND;
      KIND_RECV:    op_dec = waiting ? OP_FAULT : OP_RECV;
      KIND_SEND_AK: op_dec = waiting ? OP_FAULT : OP_SEND_AK;
      KIND_RECV_AK: op_dec = waiting ? OP_FAULT : OP_RECV_AK;
      KIND_SAMPLE: begin
        if (wait_r == WAIT_ACK) op_dec = OP_SMP_ACK;
        else if (wait_r == WAIT_BYTE) op_dec = OP_SMP_BYTE;
        else op_dec = OP_FAULT;
      end
      default:      op_dec = OP_FAULT;
    endcase
  end

  assign op_cur = (step_r == 5'd0) ? op_dec : op_r;

  assign smp_shift = cmd_r.sda_in ? (shift_r | (MSB_MASK >> bits_r[2:0])) : shift_r;
  assign smp_bits  = bits_r + 4'd1;

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    wait_nxt  = wait_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    rx_nxt    = 8'd0;
    rxv_nxt   = 1'b0;
    ack_nxt   = 1'b0;
    flt_nxt   = 1'b0;
    lst_nxt   = 1'b0;
    case (op_cur)
      OP_FAULT: begin
        flt_nxt = 1'b1;
        lst_nxt = 1'b1;
      end
      OP_START: begin
        case (step_r[1:0])
          2'd0: sda_nxt = 1'b1;
          2'd1: scl_nxt = 1'b1;
          2'd2: sda_nxt = 1'b0;
          default: begin
            scl_nxt = 1'b0;
            lst_nxt = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (step_r[1:0])
          2'd0: sda_nxt = 1'b0;
          2'd1: scl_nxt = 1'b1;
          default: begin
            sda_nxt = 1'b1;
            lst_nxt = 1'b1;
          end
        endcase
      end
      OP_SEND: begin
        // three steps per bit, MSB first: data, SCL high, SCL low
        case (phase_r)
          2'd0:    sda_nxt = cmd_r.tx_byte[~bit_r];
          2'd1:    scl_nxt = 1'b1;
          default: scl_nxt = 1'b0;
        endcase
        lst_nxt = (step_r == SEND_LAST_STEP);
      end
      OP_RECV: begin
        if (step_r == 5'd0) begin
          sda_nxt   = 1'b1;
          shift_nxt = 8'd0;
          bits_nxt  = 4'd0;
        end else begin
          scl_nxt  = 1'b1;
          wait_nxt = WAIT_BYTE;
          lst_nxt  = 1'b1;
        end
      end
      OP_SEND_AK: begin
        case (step_r[1:0])
          2'd0: sda_nxt = cmd_r.ack_value;
          2'd1: scl_nxt = 1'b1;
          default: begin
            scl_nxt = 1'b0;
            lst_nxt = 1'b1;
          end
        endcase
      end
      OP_RECV_AK: begin
        if (step_r == 5'd0) begin
          sda_nxt = 1'b1;
        end else begin
          scl_nxt  = 1'b1;
          wait_nxt = WAIT_ACK;
          lst_nxt  = 1'b1;
        end
      end
      OP_SMP_ACK: begin
        scl_nxt  = 1'b0;
        wait_nxt = WAIT_IDLE;
        rx_nxt   = {7'd0, cmd_r.sda_in};
        rxv_nxt  = 1'b1;
        ack_nxt  = 1'b1;
        lst_nxt  = 1'b1;
      end
      OP_SMP_BYTE: begin
        if (step_r == 5'd0) begin
          scl_nxt   = 1'b0;
          shift_nxt = smp_shift;
          if (smp_bits[3]) begin
            // eighth bit: report the byte on the SCL-low word
            wait_nxt = WAIT_IDLE;
            bits_nxt = 4'd0;
            rx_nxt   = smp_shift;
            rxv_nxt  = 1'b1;
            lst_nxt  = 1'b1;
          end else begin
            bits_nxt = smp_bits;
          end
        end else begin
          scl_nxt = 1'b1;
          lst_nxt = 1'b1;
        end
      end
      default: begin
        flt_nxt = 1'b1;
        lst_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      op_r        <= OP_FAULT;
      step_r      <= 5'd0;
      phase_r     <= 2'd0;
      bit_r       <= 3'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      wait_r      <= WAIT_IDLE;
      bits_r      <= 4'd0;
      shift_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        wait_r      <= wait_nxt;
        bits_r      <= bits_nxt;
        shift_r     <= shift_nxt;
        out_valid_r <= 1'b1;
        if (step_r == 5'd0) op_r <= op_dec;
        if (lst_nxt) begin
          step_r  <= 5'd0;
          phase_r <= 2'd0;
          bit_r   <= 3'd0;
        end else begin
          step_r <= step_r + 5'd1;
          if (phase_r == 2'd2) begin
            phase_r <= 2'd0;
            bit_r   <= bit_r + 3'd1;
          end else begin
            phase_r <= phase_r + 2'd1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (adv && lst_nxt) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cmd_r <= in_data;
    if (adv) begin
      out_r.scl_out   <= scl_nxt;
      out_r.sda_out   <= sda_nxt;
      out_r.rx_data   <= rx_nxt;
      out_r.rx_valid  <= rxv_nxt;
      out_r.rx_is_ack <= ack_nxt;
      out_r.fault     <= flt_nxt;
      out_r.last      <= lst_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_wait_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r == WAIT_IDLE) || (wait_r == WAIT_BYTE) || (wait_r == WAIT_ACK))
    else $error("wait mode took the unused code");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> !out_data.rx_valid && out_data.last)
    else $error("fault word carries receive data or is not final");

  a_ack_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_is_ack |-> out_data.rx_valid && out_data.rx_data[7:1] == 7'd0)
    else $error("ack word malformed");

  a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && in_ready |-> adv && lst_nxt)
    else $error("new command taken while a sequence is still running");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r[3] == 1'b0)
    else $error("receive bit count out of range");

endmodule
